[hdl/assert_macros.svh]
// Assertion macros shared by the leg kinematics RTL.
// Included by modules that check their own pipeline and queue logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[hdl/ikin_pkg.sv]
// Types, widths and constants of the two-link leg inverse kinematics block.
// No dependencies; every file but assert_macros.svh imports this package.
package ikin_pkg;

   localparam int LEN_W    = 18;            // Q2.16 lengths
   localparam int ANG_W    = 17;            // Q4.13 angles
   localparam int STAT_W   = 2;
   localparam int PROD_W   = 2 * LEN_W;     // squared length
   localparam int WIDE_W   = PROD_W + 1;    // sums and doubled products
   localparam int MSB_W    = 6;             // bit position within WIDE_W
   localparam int SH_W     = 5;             // normalize shift amount
   localparam int NORM_W   = 30;            // normalized denominator width
   localparam int SQ_W     = 2 * NORM_W;    // squared normalized values
   localparam int ROOT_W   = NORM_W;        // square root width
   localparam int REM_W    = ROOT_W + 3;    // square root remainder width
   localparam int CW       = NORM_W + 3;    // rotation datapath width
   localparam int Z_W      = 20;            // Q.16 angle accumulator
   localparam int ACOS_W   = 15;            // acos result, Q.13, 0..pi
   localparam int CORDIC_N = 17;
   localparam int ACOS_LAT = 4 + ROOT_W + CORDIC_N + 1;
   localparam int CSR_IDX_W = 1;

   localparam logic [LEN_W-1:0]  LEN_RESET = 18'd19661;
   localparam logic [ACOS_W-1:0] PI_Q13    = 15'd25736;
   localparam logic [Z_W-1:0]    PI_Q16    = 20'd205887;

   localparam logic [CSR_IDX_W-1:0] CSR_UPPER = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOWER = 1'b1;

   typedef logic [LEN_W-1:0]        len_type;
   typedef logic signed [ANG_W-1:0] ang_type;

   typedef enum logic [STAT_W-1:0] {
      CLAMP_NONE = 2'd0,
      CLAMP_FULL = 2'd1,
      CLAMP_FOLD = 2'd2
   } clamp_type;

   // Classified item between the front end and the solver.
   typedef struct packed {
      ang_type           theta;
      clamp_type         status;
      logic              gama_pi;
      logic              neg1;
      logic [WIDE_W-1:0] mag1;
      logic [WIDE_W-1:0] den1;
      logic              neg2;
      logic [WIDE_W-1:0] mag2;
      logic [WIDE_W-1:0] den2;
   } work_type;

   // Rotation angles atan(2^-i), Q.16.
   function automatic logic signed [Z_W-1:0] atan_q16(input int idx);
      logic signed [Z_W-1:0] v;
      unique case (idx)
         0:  v = 20'sd51472;
         1:  v = 20'sd30386;
         2:  v = 20'sd16055;
         3:  v = 20'sd8150;
         4:  v = 20'sd4091;
         5:  v = 20'sd2047;
         6:  v = 20'sd1024;
         7:  v = 20'sd512;
         8:  v = 20'sd256;
         9:  v = 20'sd128;
         10: v = 20'sd64;
         11: v = 20'sd32;
         12: v = 20'sd16;
         13: v = 20'sd8;
         14: v = 20'sd4;
         15: v = 20'sd2;
         16: v = 20'sd1;
         default: v = 20'sd0;
      endcase
      return v;
   endfunction

endpackage

[hdl/ikin_req_if.sv]
// Request channel of the leg kinematics block: valid, ready and one pose.
// Depends on ikin_pkg.
interface ikin_req_if import ikin_pkg::*;;
   logic    valid;
   logic    ready;
   ang_type leg_angle;
   len_type leg_length;

   modport source (output valid, output leg_angle, output leg_length, input ready);
   modport sink   (input valid, input leg_angle, input leg_length, output ready);
endinterface

[hdl/ikin_rsp_if.sv]
// Response channel of the leg kinematics block: valid, ready and joint angles.
// Depends on ikin_pkg.
interface ikin_rsp_if import ikin_pkg::*;;
   logic              valid;
   logic              ready;
   ang_type           hip_angle;
   ang_type           knee_angle;
   ang_type           ankle_angle;
   logic [STAT_W-1:0] clamp_status;

   modport source (output valid, output hip_angle, output knee_angle,
                   output ankle_angle, output clamp_status, input ready);
   modport sink   (input valid, input hip_angle, input knee_angle,
                   input ankle_angle, input clamp_status, output ready);
endinterface

[hdl/ikin_front.sv]
// Front end: takes poses, clamps against reach, forms law-of-cosines terms.
// Depends on ikin_pkg and ikin_req_if.
module ikin_front import ikin_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   ikin_req_if.sink req_ch,
   input  len_type  upper_len,
   input  len_type  lower_len,
   output logic     out_valid,
   input  logic     out_ready,
   output work_type out_item
);

   logic              adv;
   logic              a_valid_ff, b_valid_ff;
   ang_type           a_theta_ff;
   clamp_type         a_status_ff, a_status_in;
   logic              a_gpi_ff;
   logic [PROD_W-1:0] a_u2_ff, a_l2_ff, a_r2_ff, a_ul_ff, a_ur_ff;
   logic [LEN_W:0]    ext_max;
   logic [LEN_W-1:0]  ext_min;
   work_type          b_item_ff, b_item_in;
   logic [WIDE_W-1:0] s1, r2e, p2, q2;

   assign adv          = !b_valid_ff || out_ready;
   assign req_ch.ready = adv;
   assign out_valid    = b_valid_ff;
   assign out_item     = b_item_ff;

   // Reach classification
   always_comb begin
      ext_max = {1'b0, upper_len} + {1'b0, lower_len};
      ext_min = (upper_len > lower_len) ? upper_len - lower_len : lower_len - upper_len;
      priority if ({1'b0, req_ch.leg_length} >= ext_max) begin
         a_status_in = CLAMP_FULL;
      end else if (req_ch.leg_length <= ext_min) begin
         a_status_in = CLAMP_FOLD;
      end else begin
         a_status_in = CLAMP_NONE;
      end
   end

   // Cosine-law numerators and denominators
   always_comb begin
      s1  = {1'b0, a_u2_ff} + {1'b0, a_l2_ff};
      r2e = {1'b0, a_r2_ff};
      p2  = {1'b0, a_u2_ff} + {1'b0, a_r2_ff};
      q2  = {1'b0, a_l2_ff};
      b_item_in.theta   = a_theta_ff;
      b_item_in.status  = a_status_ff;
      b_item_in.gama_pi = a_gpi_ff;
      b_item_in.neg1    = r2e > s1;
      b_item_in.mag1    = (r2e > s1) ? r2e - s1 : s1 - r2e;
      b_item_in.den1    = {a_ul_ff, 1'b0};
      b_item_in.neg2    = q2 > p2;
      b_item_in.mag2    = (q2 > p2) ? q2 - p2 : p2 - q2;
      b_item_in.den2    = {a_ur_ff, 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= req_ch.valid;
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_theta_ff  <= req_ch.leg_angle;
         a_status_ff <= a_status_in;
         a_gpi_ff    <= !(upper_len > lower_len);
         a_u2_ff     <= PROD_W'(upper_len) * PROD_W'(upper_len);
         a_l2_ff     <= PROD_W'(lower_len) * PROD_W'(lower_len);
         a_r2_ff     <= PROD_W'(req_ch.leg_length) * PROD_W'(req_ch.leg_length);
         a_ul_ff     <= PROD_W'(upper_len) * PROD_W'(lower_len);
         a_ur_ff     <= PROD_W'(upper_len) * PROD_W'(req_ch.leg_length);
         b_item_ff   <= b_item_in;
      end
   end

endmodule

[hdl/ikin_fifo.sv]
// Short queue between the front end and the solver.
// Depends on ikin_pkg and assert_macros.svh.
`include "assert_macros.svh"
module ikin_fifo import ikin_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  work_type in_item,
   output logic     out_valid,
   input  logic     out_ready,
   output work_type out_item
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

   work_type          entries_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]  count_ff;
   logic              push, pop;

   assign in_ready  = count_ff != CNT_W'(DEPTH);
   assign out_valid = count_ff != '0;
   assign out_item  = entries_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= in_item;
      end
   end

   `ASSERT_NEXT(a_fifo_fill, clock, reset, push && !pop, count_ff == $past(count_ff) + 1'b1)
   `ASSERT_IMPL(a_fifo_bound, clock, reset, 1'b1, count_ff <= CNT_W'(DEPTH))

endmodule

[hdl/ikin_acos.sv]
// Pipelined acos lane: normalize, square root, rotation vectoring, round to Q.13.
// Depends on ikin_pkg.
module ikin_acos import ikin_pkg::*; (
   input  logic              clock,
   input  logic              en,
   input  logic              neg,
   input  logic [WIDE_W-1:0] mag,
   input  logic [WIDE_W-1:0] den,
   output logic [ACOS_W-1:0] angle
);

   typedef struct packed {
      logic              neg;
      logic [NORM_W-1:0] x0;
      logic [SQ_W-1:0]   rad;
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
   } sq_type;

   typedef struct packed {
      logic                  neg;
      logic signed [CW-1:0]  x;
      logic signed [CW-1:0]  y;
      logic signed [Z_W-1:0] z;
   } cd_type;

   // Normalize: find the leading one, then shift into [2^29, 2^30)
   logic              n1_neg_ff, n1_right_ff, n1_right_in;
   logic [WIDE_W-1:0] n1_den_ff, n1_mag_ff;
   logic [SH_W-1:0]   n1_amt_ff, n1_amt_in;
   logic [MSB_W-1:0]  msb_in;
   logic              n2_neg_ff;
   logic [NORM_W-1:0] n2_den_ff, n2_mag_ff;
   logic [WIDE_W-1:0] den_sh, mag_sh;
   logic              m_neg_ff;
   logic [NORM_W-1:0] m_x0_ff;
   logic [SQ_W-1:0]   m_dd_ff, m_mm_ff;
   sq_type            sq_ff [ROOT_W+1];
   cd_type            cd_ff [CORDIC_N];
   logic [Z_W-1:0]    zc, au, qv;
   logic [Z_W:0]      av;
   logic [ACOS_W-1:0] angle_ff, angle_in;

   always_comb begin
      msb_in = '0;
      for (int b = 0; b < WIDE_W; b++) begin
         if (den[b]) begin
            msb_in = MSB_W'(b);
         end
      end
      n1_right_in = msb_in > MSB_W'(NORM_W - 1);
      n1_amt_in   = n1_right_in ? SH_W'(msb_in - MSB_W'(NORM_W - 1))
                                : SH_W'(MSB_W'(NORM_W - 1) - msb_in);
   end

   always_comb begin
      den_sh = n1_right_ff ? (n1_den_ff >> n1_amt_ff) : (n1_den_ff << n1_amt_ff);
      mag_sh = n1_right_ff ? (n1_mag_ff >> n1_amt_ff) : (n1_mag_ff << n1_amt_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         n1_neg_ff   <= neg;
         n1_den_ff   <= den;
         n1_mag_ff   <= (mag > den) ? den : mag;
         n1_right_ff <= n1_right_in;
         n1_amt_ff   <= n1_amt_in;
         n2_neg_ff   <= n1_neg_ff;
         n2_den_ff   <= den_sh[NORM_W-1:0];
         n2_mag_ff   <= mag_sh[NORM_W-1:0];
         m_neg_ff    <= n2_neg_ff;
         m_x0_ff     <= n2_mag_ff;
         m_dd_ff     <= SQ_W'(n2_den_ff) * SQ_W'(n2_den_ff);
         m_mm_ff     <= SQ_W'(n2_mag_ff) * SQ_W'(n2_mag_ff);
         sq_ff[0]    <= '{neg: m_neg_ff, x0: m_x0_ff, rad: m_dd_ff - m_mm_ff,
                          rem: '0, root: '0};
      end
   end

   // Square root, one result bit per stage
   for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
      logic [REM_W-1:0] t_rem, trial;
      sq_type           nxt;
      always_comb begin
         t_rem   = {sq_ff[k].rem[REM_W-3:0], sq_ff[k].rad[SQ_W-1 -: 2]};
         trial   = {1'b0, sq_ff[k].root, 2'b01};
         nxt     = sq_ff[k];
         nxt.rad = {sq_ff[k].rad[SQ_W-3:0], 2'b00};
         if (t_rem >= trial) begin
            nxt.rem  = t_rem - trial;
            nxt.root = {sq_ff[k].root[ROOT_W-2:0], 1'b1};
         end else begin
            nxt.rem  = t_rem;
            nxt.root = {sq_ff[k].root[ROOT_W-2:0], 1'b0};
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            sq_ff[k+1] <= nxt;
         end
      end
   end

   // Vectoring rotations, one per stage
   for (genvar i = 0; i < CORDIC_N; i++) begin : g_cordic
      logic signed [CW-1:0]  cx, cy, xs, ys;
      logic signed [Z_W-1:0] cz;
      logic                  cneg;
      cd_type                nxt;
      if (i == 0) begin : g_first
         always_comb begin
            cneg = sq_ff[ROOT_W].neg;
            cx   = $signed({{(CW-NORM_W){1'b0}}, sq_ff[ROOT_W].x0});
            cy   = $signed({{(CW-ROOT_W){1'b0}}, sq_ff[ROOT_W].root});
            cz   = '0;
         end
      end else begin : g_rest
         always_comb begin
            cneg = cd_ff[i-1].neg;
            cx   = cd_ff[i-1].x;
            cy   = cd_ff[i-1].y;
            cz   = cd_ff[i-1].z;
         end
      end
      always_comb begin
         xs      = cx >>> i;
         ys      = cy >>> i;
         nxt.neg = cneg;
         if (cy >= 0) begin
            nxt.x = cx + ys;
            nxt.y = cy - xs;
            nxt.z = cz + atan_q16(i);
         end else begin
            nxt.x = cx - ys;
            nxt.y = cy + xs;
            nxt.z = cz - atan_q16(i);
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            cd_ff[i] <= nxt;
         end
      end
   end

   // Clamp, mirror for a negative cosine, round to Q.13, limit to pi
   always_comb begin
      zc = cd_ff[CORDIC_N-1].z[Z_W-1] ? '0 : cd_ff[CORDIC_N-1].z;
      av = cd_ff[CORDIC_N-1].neg ? ({1'b0, PI_Q16} - {1'b0, zc}) : {1'b0, zc};
      au = av[Z_W] ? '0 : av[Z_W-1:0];
      qv = (au + Z_W'(4)) >> 3;
      angle_in = (qv > Z_W'(PI_Q13)) ? PI_Q13 : qv[ACOS_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         angle_ff <= angle_in;
      end
   end

   assign angle = angle_ff;

endmodule

[hdl/ikin_back.sv]
// Solver back end: two acos lanes, joint angle assembly and output register.
// Depends on ikin_pkg, ikin_rsp_if, ikin_acos and assert_macros.svh.
`include "assert_macros.svh"
module ikin_back import ikin_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  work_type   in_item,
   ikin_rsp_if.source rsp_ch
);

   typedef struct packed {
      ang_type   theta;
      clamp_type status;
      logic      gama_pi;
   } side_type;

   logic                adv;
   logic [ACOS_LAT-1:0] vld_ff;
   side_type            side_ff [ACOS_LAT];
   logic [ACOS_W-1:0]   acos1, acos2, gama_in;
   ang_type             knee_in, hip_in, ankle_in;
   logic signed [ANG_W+1:0] hip_d, ankle_d;
   logic                p_valid_ff, o_valid_ff;
   ang_type             p_hip_ff, p_knee_ff, o_hip_ff, o_knee_ff, o_ankle_ff;
   clamp_type           p_status_ff, o_status_ff;
   side_type            tail;

   function automatic ang_type sat_ang(input logic signed [ANG_W+1:0] v);
      ang_type r;
      if (v < -(ANG_W+2)'(65536)) begin
         r = ang_type'(-65536);
      end else if (v > (ANG_W+2)'(65535)) begin
         r = ang_type'(65535);
      end else begin
         r = v[ANG_W-1:0];
      end
      return r;
   endfunction

   assign adv      = !o_valid_ff || rsp_ch.ready;
   assign in_ready = adv;
   assign tail     = side_ff[ACOS_LAT-1];

   ikin_acos u_acos_knee (
      .clock (clock), .en (adv), .neg (in_item.neg1),
      .mag (in_item.mag1), .den (in_item.den1), .angle (acos1));

   ikin_acos u_acos_gama (
      .clock (clock), .en (adv), .neg (in_item.neg2),
      .mag (in_item.mag2), .den (in_item.den2), .angle (acos2));

   always_comb begin
      unique case (tail.status)
         CLAMP_NONE: begin
            knee_in = ANG_W'(PI_Q13) - ANG_W'(acos1);
            gama_in = acos2;
         end
         CLAMP_FULL: begin
            knee_in = '0;
            gama_in = '0;
         end
         CLAMP_FOLD: begin
            knee_in = ANG_W'(PI_Q13);
            gama_in = tail.gama_pi ? PI_Q13 : '0;
         end
         default: begin
            knee_in = '0;
            gama_in = '0;
         end
      endcase
      hip_d  = (ANG_W+2)'(tail.theta) - $signed({{(ANG_W+2-ACOS_W){1'b0}}, gama_in});
      hip_in = sat_ang(hip_d);
   end

   always_comb begin
      ankle_d  = -((ANG_W+2)'(p_hip_ff) + (ANG_W+2)'(p_knee_ff));
      ankle_in = sat_ang(ankle_d);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         p_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff     <= {vld_ff[ACOS_LAT-2:0], in_valid};
         p_valid_ff <= vld_ff[ACOS_LAT-1];
         o_valid_ff <= p_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= '{theta: in_item.theta, status: in_item.status,
                         gama_pi: in_item.gama_pi};
         for (int s = 1; s < ACOS_LAT; s++) begin
            side_ff[s] <= side_ff[s-1];
         end
         p_hip_ff    <= hip_in;
         p_knee_ff   <= knee_in;
         p_status_ff <= tail.status;
         o_hip_ff    <= p_hip_ff;
         o_knee_ff   <= p_knee_ff;
         o_ankle_ff  <= ankle_in;
         o_status_ff <= p_status_ff;
      end
   end

   assign rsp_ch.valid        = o_valid_ff;
   assign rsp_ch.hip_angle    = o_hip_ff;
   assign rsp_ch.knee_angle   = o_knee_ff;
   assign rsp_ch.ankle_angle  = o_ankle_ff;
   assign rsp_ch.clamp_status = o_status_ff;

   `ASSERT_NEXT(a_back_advance, clock, reset, p_valid_ff && adv, o_valid_ff)
   `ASSERT_IMPL(a_fold_knee, clock, reset, o_valid_ff && (o_status_ff == CLAMP_FOLD), o_knee_ff == ANG_W'(PI_Q13))
   `ASSERT_IMPL(a_full_knee, clock, reset, o_valid_ff && (o_status_ff == CLAMP_FULL), o_knee_ff == '0)

endmodule

[hdl/two_link_leg_inverse_kinematics_unit.sv]
// Two-link leg inverse kinematics: each request carries a leg direction
// (signed Q4.13 rad) and a hip-to-ankle distance (unsigned Q2.16 m); each
// response returns hip, knee and ankle angles (signed Q4.13 rad) and the
// reach clamp applied (0 in reach, 1 full extension, 2 folded). The unit
// takes one request per clock while the response channel does not stall
// it, and returns one response per request, in order. Requests pass through
// the front end, the queue and the solver (normalize, a 30-stage square root, 17
// rotation stages, rounding and angle assembly). Thigh and shank lengths
// are set through the csr_ port (index 0 upper, 1 lower, both reset to
// 0.3 m) and must only be written while no request is in flight.
// Depends on ikin_pkg, the channel interfaces, ikin_front, ikin_fifo, ikin_back.
module two_link_leg_inverse_kinematics_unit import ikin_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   ikin_req_if.sink             req_ch,
   ikin_rsp_if.source           rsp_ch,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [LEN_W-1:0]     csr_wdata
);

   len_type  upper_ff, lower_ff;
   logic     f_valid, f_ready, q_valid, q_ready;
   work_type f_item, q_item;

   // Leg length registers; hold between writes
   always_ff @(posedge clock) begin
      if (reset) begin
         upper_ff <= LEN_RESET;
         lower_ff <= LEN_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_UPPER: upper_ff <= csr_wdata;
            CSR_LOWER: lower_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Classify reach and form cosine-law terms
   ikin_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .upper_len (upper_ff),
      .lower_len (lower_ff),
      .out_valid (f_valid),
      .out_ready (f_ready),
      .out_item  (f_item)
   );

   // Decouple front end stalls from solver stalls
   ikin_fifo #(.DEPTH (QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_item   (f_item),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_item  (q_item)
   );

   // Solve both angles and drive each response transfer
   ikin_back u_back (
      .clock    (clock),
      .reset    (reset),
      .in_valid (q_valid),
      .in_ready (q_ready),
      .in_item  (q_item),
      .rsp_ch   (rsp_ch)
   );

endmodule

[test/two_link_leg_inverse_kinematics_unit_tb.sv]
// Testbench for two_link_leg_inverse_kinematics_unit: random and directed poses,
// checked against an in-bench fixed-point solver across several leg lengths.
// Depends on ikin_pkg, ikin_req_if, ikin_rsp_if and the unit itself.
`timescale 1ns / 1ps

module two_link_leg_inverse_kinematics_unit_tb;
   import ikin_pkg::*;

   localparam int  CLOCK_HALF   = 4;
   localparam int  RESET_CYCLES = 4;
   localparam int  CYCLE_LIMIT  = 400000;
   localparam int  DRAIN_CYCLES = 120;
   localparam int  PHASE_COUNT  = 9;
   localparam int  RANDOM_PER_PHASE = 150;
   localparam longint ANGLE_MIN = -65536;
   localparam longint ANGLE_MAX = 65535;

   typedef struct {
      ang_type angle;
      len_type length;
   } pose_type;

   typedef struct {
      ang_type   hip;
      ang_type   knee;
      ang_type   ankle;
      clamp_type status;
   } joints_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [LEN_W-1:0] csr_wdata;

   ikin_req_if req_if ();
   ikin_rsp_if rsp_if ();

   two_link_leg_inverse_kinematics_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_if),
      .rsp_ch    (rsp_if),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Predictor copy of the leg lengths
   longint unsigned thigh_len = LEN_RESET;
   longint unsigned shank_len = LEN_RESET;

   pose_type   pending_poses[$];
   joints_type expected_joints[$];
   pose_type   held_pose;
   int         send_idle_pct;
   int         recv_idle_pct;
   int         mismatch_count;
   int         cycle_count;

   // Integer square root, floor
   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned root;
      longint unsigned bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= root + bitv) begin
            v = v - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return root;
   endfunction

   // acos of (+/-)mag/den by normalized vectoring rotation, Q4.13 in [0, pi]
   function automatic longint arc_cos_q13(bit neg, longint unsigned mag,
                                          longint unsigned den);
      longint x, y, z, a, xs, ys;
      longint atans[CORDIC_N];
      atans = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512, 256,
                128, 64, 32, 16, 8, 4, 2, 1};
      z = 0;
      if (den == 0) return 0;
      if (mag > den) mag = den;
      while (den >= (64'd1 << 30)) begin
         den >>= 1;
         mag >>= 1;
      end
      while (den < (64'd1 << 29)) begin
         den <<= 1;
         mag <<= 1;
      end
      x = longint'(mag);
      y = longint'(int_sqrt(den * den - mag * mag));
      for (int i = 0; i < CORDIC_N; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x += ys;
            y -= xs;
            z += atans[i];
         end else begin
            x -= ys;
            y += xs;
            z -= atans[i];
         end
      end
      if (z < 0) z = 0;
      a = neg ? longint'(PI_Q16) - z : z;
      if (a < 0) a = 0;
      a = (a + 4) >>> 3;
      if (a > longint'(PI_Q13)) a = PI_Q13;
      return a;
   endfunction

   function automatic longint clip_angle(longint v);
      if (v < ANGLE_MIN) return ANGLE_MIN;
      if (v > ANGLE_MAX) return ANGLE_MAX;
      return v;
   endfunction

   // Expected joint angles for one pose under the current leg lengths
   function automatic joints_type solve_leg(pose_type p);
      joints_type res;
      longint unsigned r, ext_max, ext_min, r2, s1, p2, q2;
      longint theta, knee, gama, hip;
      bit neg1, neg2;
      theta = longint'(p.angle);
      r = p.length;
      ext_max = thigh_len + shank_len;
      ext_min = (thigh_len > shank_len) ? thigh_len - shank_len : shank_len - thigh_len;
      if (r >= ext_max) begin
         res.status = CLAMP_FULL;
         knee = 0;
         gama = 0;
      end else if (r <= ext_min) begin
         res.status = CLAMP_FOLD;
         knee = PI_Q13;
         gama = (thigh_len > shank_len) ? 0 : longint'(PI_Q13);
      end else begin
         r2 = r * r;
         s1 = thigh_len * thigh_len + shank_len * shank_len;
         p2 = thigh_len * thigh_len + r2;
         q2 = shank_len * shank_len;
         neg1 = r2 > s1;
         neg2 = q2 > p2;
         res.status = CLAMP_NONE;
         knee = longint'(PI_Q13) - arc_cos_q13(neg1, neg1 ? r2 - s1 : s1 - r2,
                                               2 * thigh_len * shank_len);
         gama = arc_cos_q13(neg2, neg2 ? q2 - p2 : p2 - q2, 2 * thigh_len * r);
      end
      hip = clip_angle(theta - gama);
      res.hip   = ang_type'(hip);
      res.knee  = ang_type'(knee);
      res.ankle = ang_type'(clip_angle(-(hip + knee)));
      return res;
   endfunction

   // Clock and cycle limit
   initial begin
      clock = 1'b0;
      forever #(CLOCK_HALF) clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("two_link_leg_inverse_kinematics_unit regression: fail");
         $finish;
      end
   end

   // Driver: present pending poses, hold each until its transfer completes
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         // Record the expected joints of a completed transfer
         if (req_if.valid && req_if.ready)
            expected_joints.insert(expected_joints.size(), solve_leg(held_pose));
         // Advance only when the channel is free
         if (!req_if.valid || req_if.ready) begin
            if (pending_poses.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               held_pose = pending_poses.pop_front();
               req_if.valid      <= 1'b1;
               req_if.leg_angle  <= held_pose.angle;
               req_if.leg_length <= held_pose.length;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: stall at random, compare each transfer with the oldest expectation
   always @(posedge clock) begin
      joints_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_joints.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected result: hip %0d knee %0d ankle %0d status %0d",
                           rsp_if.hip_angle, rsp_if.knee_angle, rsp_if.ankle_angle,
                           rsp_if.clamp_status);
            end else begin
               want = expected_joints.pop_front();
               if (rsp_if.hip_angle !== want.hip || rsp_if.knee_angle !== want.knee ||
                   rsp_if.ankle_angle !== want.ankle ||
                   rsp_if.clamp_status !== want.status) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("mismatch: expected %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
                              want.hip, want.knee, want.ankle, want.status,
                              rsp_if.hip_angle, rsp_if.knee_angle,
                              rsp_if.ankle_angle, rsp_if.clamp_status);
               end
            end
         end
         rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Write one leg length; the unit is idle whenever this is called
   task automatic write_leg_length(logic [CSR_IDX_W-1:0] idx, len_type value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_UPPER) thigh_len = value;
      else                  shank_len = value;
   endtask

   function automatic void queue_pose(longint angle, longint length);
      pose_type p;
      p.angle  = ang_type'(angle);
      p.length = len_type'(length);
      pending_poses.insert(pending_poses.size(), p);
   endfunction

   // Angle extremes, both reach limits, the fold limit and its neighbor
   function automatic void queue_directed_poses();
      longint unsigned ext_max, ext_min;
      ext_max = thigh_len + shank_len;
      ext_min = (thigh_len > shank_len) ? thigh_len - shank_len : shank_len - thigh_len;
      queue_pose(ANGLE_MIN, 0);
      queue_pose(ANGLE_MAX, 262143);
      queue_pose(0, (ext_max > 262143) ? 262143 : ext_max);
      queue_pose(ANGLE_MIN, ext_min);
      queue_pose(ANGLE_MAX, ext_min + 1);
      queue_pose(1234, (ext_min + ext_max) / 2);
   endfunction

   // Mostly reachable distances, the rest anywhere in the field
   function automatic void queue_random_poses(int count);
      longint unsigned ext_max, ext_min, hi;
      longint length;
      ext_max = thigh_len + shank_len;
      ext_min = (thigh_len > shank_len) ? thigh_len - shank_len : shank_len - thigh_len;
      hi = (ext_max - 1 > 262143) ? 262143 : ext_max - 1;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(99) < 80 && hi >= ext_min + 1)
            length = $urandom_range(hi, ext_min + 1);
         else
            length = $urandom_range(262143);
         queue_pose(longint'($signed(17'($urandom))), length);
      end
   endfunction

   // Stimulus sequence
   initial begin
      len_type phase_upper[PHASE_COUNT];
      len_type phase_lower[PHASE_COUNT];
      phase_upper = '{19661, 1, 262143, 262143, 1, 40000, 20000, 0, 0};
      phase_lower = '{19661, 1, 262143, 1, 262143, 25000, 45000, 0, 0};
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = CSR_UPPER;
      csr_wdata = '0;
      req_if.valid = 1'b0;
      req_if.leg_angle = '0;
      req_if.leg_length = '0;
      rsp_if.ready = 1'b0;
      send_idle_pct = 14;
      recv_idle_pct = 61;
      mismatch_count = 0;
      cycle_count = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         // Swap idling profile per third of the run
         if (ph < 3) begin
            send_idle_pct = 14;
            recv_idle_pct = 61;
         end else if (ph < 6) begin
            send_idle_pct = 61;
            recv_idle_pct = 14;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if (ph >= 7) begin
            phase_upper[ph] = $urandom_range(262143, 1);
            phase_lower[ph] = $urandom_range(262143, 1);
         end
         write_leg_length(CSR_UPPER, phase_upper[ph]);
         write_leg_length(CSR_LOWER, phase_lower[ph]);
         if (ph == 0 || ph == 3 || ph == 4 || ph == 6) queue_directed_poses();
         queue_random_poses(RANDOM_PER_PHASE);
         // Hold the sender until every result of this phase is back
         while (pending_poses.size() > 0 || req_if.valid || expected_joints.size() > 0)
            @(posedge clock);
         repeat (DRAIN_CYCLES) @(posedge clock);
      end

      if (mismatch_count == 0 && expected_joints.size() == 0)
         $display("two_link_leg_inverse_kinematics_unit regression: pass");
      else
         $display("two_link_leg_inverse_kinematics_unit regression: fail");
      $finish;
   end

endmodule
